### sv/aps_pkg.sv
`timescale 1ns / 1ps
// aps_pkg: shared types and constants of the aging peer signal table.
// No dependencies; every other file but aps_if refers to it by scoped names.
package aps_pkg;

  // Input action codes
  localparam logic [1:0] ACT_SIGHTING  = 2'd0;
  localparam logic [1:0] ACT_MAINTAIN  = 2'd1;
  localparam logic [1:0] ACT_SCAN_DONE = 2'd2;
  localparam logic [1:0] ACT_QUERY     = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_ADDED   = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_OTHER   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_INTERVAL  = 2'd0;
  localparam logic [1:0] REG_READY     = 2'd1;
  localparam logic [1:0] REG_SUSPENDED = 2'd2;

  localparam logic [19:0]        INTERVAL_RESET = 20'd10000;
  localparam logic signed [7:0]  LEVEL_FLOOR    = -8'sd127;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Work kinds decided by the front end
  typedef enum logic [2:0] {
    OP_SIGHT,
    OP_IGNORE,
    OP_MAINT,
    OP_SCAN_DONE,
    OP_QUERY
  } op_t;

  typedef struct packed {
    logic [19:0] interval;
    logic        ready;
    logic        suspended;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic [63:0]        key;
    logic signed [7:0]  level;
    logic [31:0]        now;
  } job_t;

  typedef struct packed {
    logic [63:0]        key;
    logic signed [7:0]  level;
    logic [31:0]        last_seen;
  } entry_t;

endpackage

### sv/aps_if.sv
`timescale 1ns / 1ps
// aps_if: valid/ready channel interfaces of the peer table (items, results,
// configuration writes). Depends on nothing.
interface aps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic               name_matches;
  logic [63:0]        peer_key;
  logic signed [7:0]  signal_level;
  logic [31:0]        now_ms;

  modport source (output valid, action, name_matches, peer_key, signal_level, now_ms,
                  input ready);
  modport sink (input valid, action, name_matches, peer_key, signal_level, now_ms,
                output ready);
endinterface

interface aps_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic               peer_seen;
  logic signed [7:0]  nearest_level;
  logic [3:0]         peer_count;
  logic               start_scan;

  modport source (output valid, status, peer_seen, nearest_level, peer_count, start_scan,
                  input ready);
  modport sink (input valid, status, peer_seen, nearest_level, peer_count, start_scan,
                output ready);
endinterface

interface aps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/aps_front.sv
`timescale 1ns / 1ps
// aps_front: accepts input items and classifies them into table jobs.
// Depends on aps_pkg and aps_if.
module aps_front (
  aps_in_if.sink       item,
  input  aps_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          push,
  output aps_pkg::job_t push_job
);

  aps_pkg::op_t op;

  always_comb begin
    case (item.action)
      aps_pkg::ACT_SIGHTING: begin
        op = item.name_matches ? aps_pkg::OP_SIGHT : aps_pkg::OP_IGNORE;
      end
      aps_pkg::ACT_MAINTAIN: begin
        // skipped maintenance only reports
        op = (cfg.ready && !cfg.suspended) ? aps_pkg::OP_MAINT : aps_pkg::OP_QUERY;
      end
      aps_pkg::ACT_SCAN_DONE: begin
        op = aps_pkg::OP_SCAN_DONE;
      end
      default: begin
        op = aps_pkg::OP_QUERY;
      end
    endcase
  end

  assign item.ready     = !q_full;
  assign push           = item.valid && !q_full;
  assign push_job.op    = op;
  assign push_job.key   = item.peer_key;
  assign push_job.level = item.signal_level;
  assign push_job.now   = item.now_ms;

endmodule

### sv/aps_queue.sv
`timescale 1ns / 1ps
// aps_queue: short job queue between front end and table engine.
// Depends on aps_pkg.
module aps_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  aps_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output aps_pkg::job_t head
);

  aps_pkg::job_t                slots [aps_pkg::QUEUE_DEPTH];
  logic [aps_pkg::QPTR_W-1:0]   wr_ptr;
  logic [aps_pkg::QPTR_W-1:0]   rd_ptr;
  logic [aps_pkg::QCNT_W-1:0]   fill;

  localparam logic [aps_pkg::QPTR_W-1:0] LAST = aps_pkg::QPTR_W'(aps_pkg::QUEUE_DEPTH - 1);

  assign full      = (fill == aps_pkg::QCNT_W'(aps_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (!(push && full)) else $error("aps_queue: push into full queue");
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("aps_queue: pop from empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= aps_pkg::QCNT_W'(aps_pkg::QUEUE_DEPTH))
    else $error("aps_queue: fill count above depth");

  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> fill == $past(fill) + 1'b1)
    else $error("aps_queue: fill count did not advance on push");

endmodule

### sv/aps_engine.sv
`timescale 1ns / 1ps
// aps_engine: table memory and the walk that updates, evicts and reports.
// Depends on aps_pkg and aps_if.
module aps_engine #(
  parameter int MAX_PEERS = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  aps_pkg::cfg_t cfg,
  input  logic          q_not_empty,
  input  aps_pkg::job_t q_head,
  output logic          q_pop,
  aps_out_if.source     result
);

  localparam int CNT_W = $clog2(MAX_PEERS + 1);
  localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PEERS);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

  state_t              state;
  aps_pkg::job_t       job;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    ev_idx;
  logic [CNT_W-1:0]    wr_ptr;
  logic                ev_valid;
  logic                found;
  logic                seen_acc;
  logic signed [7:0]   best_acc;
  logic                scan_running;
  logic [31:0]         last_scan;
  logic [20:0]         lim_evict;
  logic [21:0]         lim_window;

  logic                res_valid;
  logic [2:0]          res_status;
  logic                res_seen;
  logic signed [7:0]   res_best;
  logic [3:0]          res_count;
  logic                res_start;

  aps_pkg::entry_t     mem [MAX_PEERS];
  aps_pkg::entry_t     rd_data;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  aps_pkg::entry_t     mem_wdata;
  logic                issue;

  logic [31:0]         diff;
  logic                key_hit;
  logic                keep;
  logic signed [7:0]   ev_level;
  logic                ev_near;
  logic                add_ok;
  logic                scan_go;
  logic [CNT_W-1:0]    fin_cnt;
  logic                fin_seen;
  logic signed [7:0]   fin_best;
  logic [2:0]          fin_status;

  assign q_pop = (state == S_IDLE) && q_not_empty && !res_valid;
  assign issue = (state == S_WALK) && (rd_idx < cnt);

  // Evaluate the entry read last cycle
  assign diff     = job.now - rd_data.last_seen;
  assign key_hit  = (job.op == aps_pkg::OP_SIGHT) && (rd_data.key == job.key);
  assign keep     = (job.op != aps_pkg::OP_MAINT) || (diff <= {11'd0, lim_evict});
  assign ev_level = key_hit ? job.level : rd_data.level;
  assign ev_near  = key_hit ? (lim_window != '0) : (diff < {10'd0, lim_window});

  assign add_ok  = (job.op == aps_pkg::OP_SIGHT) && !found && (cnt < CNT_MAX);
  assign scan_go = (job.op == aps_pkg::OP_MAINT) && !scan_running &&
                   ((job.now - last_scan) >= {12'd0, cfg.interval});

  always_comb begin
    if (add_ok) begin
      fin_cnt = cnt + 1'b1;
    end else if (job.op == aps_pkg::OP_MAINT) begin
      fin_cnt = wr_ptr;
    end else begin
      fin_cnt = cnt;
    end
    fin_seen = seen_acc || (add_ok && (lim_window != '0));
    fin_best = (add_ok && (job.level > best_acc)) ? job.level : best_acc;
    case (job.op)
      aps_pkg::OP_SIGHT: begin
        if (found) begin
          fin_status = aps_pkg::ST_UPDATED;
        end else if (add_ok) begin
          fin_status = aps_pkg::ST_ADDED;
        end else begin
          fin_status = aps_pkg::ST_DROPPED;
        end
      end
      aps_pkg::OP_IGNORE: begin
        fin_status = aps_pkg::ST_IGNORED;
      end
      default: begin
        fin_status = aps_pkg::ST_OTHER;
      end
    endcase
  end

  // Single write port: in-place update, compaction, or append
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ev_idx[IDX_W-1:0];
    mem_wdata = rd_data;
    if (state == S_WALK && ev_valid) begin
      if (key_hit) begin
        mem_we    = 1'b1;
        mem_waddr = ev_idx[IDX_W-1:0];
        mem_wdata = '{key: job.key, level: job.level, last_seen: job.now};
      end else if (job.op == aps_pkg::OP_MAINT && keep) begin
        mem_we    = 1'b1;
        mem_waddr = wr_ptr[IDX_W-1:0];
        mem_wdata = rd_data;
      end
    end else if (state == S_FINISH && add_ok) begin
      mem_we    = 1'b1;
      mem_waddr = cnt[IDX_W-1:0];
      mem_wdata = '{key: job.key, level: job.level, last_seen: job.now};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data <= mem[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      scan_running <= 1'b0;
      last_scan    <= '0;
      res_valid    <= 1'b0;
      ev_valid     <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            job        <= q_head;
            rd_idx     <= '0;
            wr_ptr     <= '0;
            ev_valid   <= 1'b0;
            found      <= 1'b0;
            seen_acc   <= 1'b0;
            best_acc   <= aps_pkg::LEVEL_FLOOR;
            lim_evict  <= {cfg.interval, 1'b0};
            lim_window <= {2'd0, cfg.interval} + {1'b0, cfg.interval, 1'b0};
            state      <= S_WALK;
          end
        end
        S_WALK: begin
          ev_valid <= issue;
          if (issue) begin
            ev_idx <= rd_idx;
            rd_idx <= rd_idx + 1'b1;
          end
          if (ev_valid) begin
            if (key_hit) begin
              found <= 1'b1;
            end
            if (job.op == aps_pkg::OP_MAINT && keep) begin
              wr_ptr <= wr_ptr + 1'b1;
            end
            if (keep) begin
              seen_acc <= seen_acc || ev_near;
              if (ev_level > best_acc) begin
                best_acc <= ev_level;
              end
            end
          end
          if (!issue && !ev_valid) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          cnt        <= fin_cnt;
          res_valid  <= 1'b1;
          res_status <= fin_status;
          res_seen   <= cfg.ready && fin_seen;
          res_best   <= (cfg.ready && fin_cnt != '0) ? fin_best : 8'sd0;
          res_count  <= 4'(fin_cnt);
          res_start  <= scan_go;
          if (scan_go) begin
            scan_running <= 1'b1;
            last_scan    <= job.now;
          end
          if (job.op == aps_pkg::OP_SCAN_DONE) begin
            scan_running <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid         = res_valid;
  assign result.status        = res_status;
  assign result.peer_seen     = res_seen;
  assign result.nearest_level = res_best;
  assign result.peer_count    = res_count;
  assign result.start_scan    = res_start;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CNT_MAX)
    else $error("aps_engine: entry count above table size");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> wr_ptr <= rd_idx)
    else $error("aps_engine: compaction pointer ran ahead of read pointer");

  a_pop_slot_free: assert property (@(posedge clk) disable iff (rst) q_pop |-> !res_valid)
    else $error("aps_engine: job taken while result still pending");

  a_scan_flag: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && scan_go) |=> scan_running && res_start)
    else $error("aps_engine: scan start not recorded");

endmodule

### sv/aging_peer_signal_table.sv
`timescale 1ns / 1ps
// aging_peer_signal_table: top level; configuration registers and the
// front end, job queue and table engine. Depends on aps_pkg, aps_if, submodules.
//
// Usage:
//   item   - input items (sighting, maintain tick, scan finished, query),
//            one transfer per valid && ready edge.
//   result - exactly one result per item, in item order, from an output
//            register; the engine picks up the next job once it is taken.
//   cfg    - register writes (0 interval, 1 radio ready, 2 suspended),
//            always ready, applied on the next edge; write only while idle.
// Path: a job passes through the job queue, then the engine's idle, walk
//   and finish states; the walk covers the stored peers (up to MAX_PEERS).
//   The walk reads one entry per cycle from the single read port of the
//   table memory; that walk sets the rate, one item at a time.
// The engine takes a new job only once the previous result has been taken.
// The two-entry queue lets items enter while the engine is busy; item.ready
//   drops only when the queue is full.
// Reset: empties the table and queue, clears the scan flag and last scan time,
//   loads the interval with 10000 ms and clears ready and suspended. Entries
//   need no clearing pass: only entries below the count are ever read.
// A stalled receiver holds the result register and, behind it, the engine
//   and then the queue; nothing is lost.
module aging_peer_signal_table #(
  parameter int MAX_PEERS = 10
) (
  input  logic      clk,
  input  logic      rst,
  aps_in_if.sink    item,
  aps_out_if.source result,
  aps_cfg_if.sink   cfg
);

  aps_pkg::cfg_t cfg_regs;
  logic          q_full;
  logic          q_push;
  aps_pkg::job_t q_push_job;
  logic          q_pop;
  logic          q_not_empty;
  aps_pkg::job_t q_head;

  // Configuration registers; writes beyond the list are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.interval  <= aps_pkg::INTERVAL_RESET;
      cfg_regs.ready     <= 1'b0;
      cfg_regs.suspended <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        aps_pkg::REG_INTERVAL:  cfg_regs.interval  <= cfg.data;
        aps_pkg::REG_READY:     cfg_regs.ready     <= cfg.data[0];
        aps_pkg::REG_SUSPENDED: cfg_regs.suspended <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // Classify items and hand them to the queue
  aps_front u_front (
    .item     (item),
    .cfg      (cfg_regs),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (q_push_job)
  );

  aps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Walk the table, update it and produce the result
  aps_engine #(
    .MAX_PEERS (MAX_PEERS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_regs),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .result      (result)
  );

endmodule
